FILE: hw/rtl/src_pkg.sv
// shared types, constants and arithmetic helpers for the sensor compensation block
package src_pkg;

    // item field widths
    localparam int PRESS_RAW_W = 20;
    localparam int TEMP_RAW_W  = 20;
    localparam int HUM_RAW_W   = 16;
    localparam int TEMP_W      = 32;
    localparam int PRESS_W     = 24;
    localparam int HUM_W       = 14;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 72;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_WORDS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW_WORDS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH_WORDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIXED_WORDS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_WORDS        = 3'd4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // divider geometry: 64-bit dividend, 32-bit divisor
    localparam int NUM_W = 64;
    localparam int DEN_W = 32;

    // compensation constants
    localparam logic [32:0] PRESS_FINE_OFS = 33'd128000;
    localparam logic [20:0] PRESS_FULL     = 21'd1048576;
    localparam logic [31:0] PRESS_SCALE    = 32'd3125;
    localparam logic [63:0] PRESS_V1_BIAS  = 64'h0000_8000_0000_0000;
    localparam logic [31:0] HUM_FINE_OFS   = 32'd76800;
    localparam logic [31:0] HUM_MAX_Q10    = 32'd419430400;
    localparam logic [31:0] HUM_INNER_OFS  = 32'd2097152;
    localparam logic [31:0] HUM_ROUND_14   = 32'd16384;
    localparam logic [31:0] HUM_ROUND_13   = 32'd8192;
    localparam logic [31:0] HUM_H3_OFS     = 32'd32768;
    localparam logic [31:0] HUM_ROUND_12   = 32'd2048;
    localparam logic [23:0] HUM_ROUND_10   = 24'd512;
    localparam logic [23:0] HUM_PCT        = 24'd100;
    localparam logic [31:0] PRESS_ROUND_8  = 32'd128;
    localparam logic [31:0] TEMP_ROUND_8   = 32'd128;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
    } t_side;

    // front to back item: divider operands plus finished fields
    typedef struct packed {
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
        t_side            side;
    } t_pre;

    // divider result
    typedef struct packed {
        logic [NUM_W-1:0] quo;
        logic             zero;
        t_side            side;
    } t_quot;

    function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

    // unsigned 32-bit low half times signed 16-bit word, exact, sign extended
    function automatic logic [63:0] mul_u32_s16(input logic [31:0] a, input logic [15:0] b);
        logic signed [48:0] m;
        m = $signed({1'b0, a}) * $signed(b);
        return {{15{m[48]}}, m};
    endfunction

    function automatic logic [63:0] mul_s33_s16(input logic [32:0] a, input logic [15:0] b);
        logic signed [48:0] m;
        m = $signed(a) * $signed(b);
        return {{15{m[48]}}, m};
    endfunction

    function automatic logic [63:0] mul_s33_s33(input logic [32:0] a, input logic [32:0] b);
        logic signed [65:0] m;
        m = $signed(a) * $signed(b);
        return m[63:0];
    endfunction

    function automatic logic [63:0] mul_s32_s32(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] m;
        m = $signed(a) * $signed(b);
        return m;
    endfunction

endpackage

FILE: hw/rtl/sensor_reading_compensation.sv
// Environmental sensor compensation, integer form.
// Input stream: one item per set of raw readings, accepted when i_s_axis_tvalid and
// o_s_axis_tready are both high. Output stream: one item per input item, in order,
// taken when o_m_axis_tvalid and i_m_axis_tready are both high.
// Calibration words are written through i_cfg_wr_en / i_cfg_index / i_cfg_data, one
// register per write; writes to unused indexes are dropped. The user must write them
// only while no item is in flight; the block itself does not enforce this.
// Items pass 10 front stages, one queue slot, 66 divider stages (64 quotient bits,
// entry and sign fix) and 4 back stages. Throughput is one item per cycle while
// nothing stalls; the bit-per-stage divider pipeline sets the depth, not the rate.
// When the receiver stalls, the back pipeline holds and the 4-entry queue absorbs
// items; the front keeps accepting until the queue and its own last stage are full.
// Reset clears all valid bits, the queue and the calibration registers; no item is
// lost or duplicated across a stall.
// Temperature comes out in 0.01 degC, pressure in whole Pa (0 when the divisor is 0),
// humidity in 0.01 %RH clamped to 0..10000.
module sensor_reading_compensation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // press_raw [19:0], temp_raw [39:20], hum_raw [55:40]
    input  logic [src_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // temp_centideg [31:0], press_pascal [55:32], hum_centipct [69:56], zero [71:70]
    output logic [src_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [src_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [src_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import src_pkg::*;

    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_press_low;
    logic [63:0] r_cal_press_high;
    logic [55:0] r_cal_mixed;
    logic [31:0] r_cal_hum;

    logic w_front_vld, w_front_rdy, w_q_vld, w_q_rdy;
    t_pre w_front_data, w_q_data;
    logic [TEMP_W-1:0]  w_temp;
    logic [PRESS_W-1:0] w_press;
    logic [HUM_W-1:0]   w_hum;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp       <= '0;
            r_cal_press_low  <= '0;
            r_cal_press_high <= '0;
            r_cal_mixed      <= '0;
            r_cal_hum        <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TEMP_WORDS:       r_cal_temp       <= i_cfg_data[47:0];
                CFG_PRESS_LOW_WORDS:  r_cal_press_low  <= i_cfg_data;
                CFG_PRESS_HIGH_WORDS: r_cal_press_high <= i_cfg_data;
                CFG_MIXED_WORDS:      r_cal_mixed      <= i_cfg_data[55:0];
                CFG_HUM_WORDS:        r_cal_hum        <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    src_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_press_raw      (i_s_axis_tdata[19:0]),
        .i_temp_raw       (i_s_axis_tdata[39:20]),
        .i_hum_raw        (i_s_axis_tdata[55:40]),
        .i_cal_temp       (r_cal_temp),
        .i_cal_press_low  (r_cal_press_low),
        .i_cal_press_high (r_cal_press_high),
        .i_cal_mixed      (r_cal_mixed),
        .i_cal_hum        (r_cal_hum),
        .o_valid          (w_front_vld),
        .i_ready          (w_front_rdy),
        .o_data           (w_front_data)
    );

    src_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_vld),
        .o_ready (w_front_rdy),
        .i_data  (w_front_data),
        .o_valid (w_q_vld),
        .i_ready (w_q_rdy),
        .o_data  (w_q_data)
    );

    src_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_q_vld),
        .o_ready          (w_q_rdy),
        .i_data           (w_q_data),
        .i_cal_press_high (r_cal_press_high),
        .i_cal_mixed      (r_cal_mixed),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_temp           (w_temp),
        .o_press          (w_press),
        .o_hum            (w_hum)
    );

    assign o_m_axis_tdata = {2'b00, w_hum, w_press, w_temp};

`ifndef SYNTHESIS
    // humidity never leaves the clamp range
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[69:56] <= 14'd10000))
        else $error("humidity above 100 percent");

    // a front item refused by the full queue stays put
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_front_vld && !w_front_rdy) |=> (w_front_vld && $stable(w_front_data)))
        else $error("front item changed while queue full");

    // room in the queue always lets the input side move
    a_front_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_rdy |-> o_s_axis_tready)
        else $error("input stalled with room in the queue");
`endif

endmodule

FILE: hw/rtl/src_front.sv
// front part: accepts raw readings, computes temperature, humidity and divider operands
module src_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [src_pkg::PRESS_RAW_W-1:0] i_press_raw,
    input  logic [src_pkg::TEMP_RAW_W-1:0]  i_temp_raw,
    input  logic [src_pkg::HUM_RAW_W-1:0]   i_hum_raw,
    input  logic [47:0]                   i_cal_temp,
    input  logic [63:0]                   i_cal_press_low,
    input  logic [63:0]                   i_cal_press_high,
    input  logic [55:0]                   i_cal_mixed,
    input  logic [31:0]                   i_cal_hum,
    output logic                          o_valid,
    input  logic                          i_ready,
    output src_pkg::t_pre                 o_data
);
    import src_pkg::*;

    localparam int STAGES = 10;

    // calibration words
    logic [15:0] w_t1, w_t2, w_t3;
    logic [15:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6;
    logic [7:0]  w_h1, w_h3, w_h6;
    logic [15:0] w_h2, w_h4, w_h5;

    assign w_t1 = i_cal_temp[15:0];
    assign w_t2 = i_cal_temp[31:16];
    assign w_t3 = i_cal_temp[47:32];
    assign w_p1 = i_cal_press_low[15:0];
    assign w_p2 = i_cal_press_low[31:16];
    assign w_p3 = i_cal_press_low[47:32];
    assign w_p4 = i_cal_press_low[63:48];
    assign w_p5 = i_cal_press_high[15:0];
    assign w_p6 = i_cal_press_high[31:16];
    assign w_h1 = i_cal_mixed[23:16];
    assign w_h2 = i_cal_mixed[39:24];
    assign w_h3 = i_cal_mixed[47:40];
    assign w_h6 = i_cal_mixed[55:48];
    assign w_h4 = i_cal_hum[15:0];
    assign w_h5 = i_cal_hum[31:16];

    logic             w_en;
    logic [STAGES-1:0] r_vld;

    // stage registers
    logic [31:0] r_s0_ap, r_s0_dd;
    logic [PRESS_RAW_W-1:0] r_s0_praw, r_s1_praw, r_s2_praw, r_s3_praw, r_s4_praw, r_s5_praw;
    logic [HUM_RAW_W-1:0]   r_s0_hraw, r_s1_hraw, r_s2_hraw, r_s3_hraw;
    logic [31:0] r_s1_a, r_s1_b1;
    logic [31:0] r_s2_fine;
    logic [TEMP_W-1:0] r_s2_temp, r_s3_temp, r_s4_temp, r_s5_temp, r_s6_temp, r_s7_temp,
                       r_s8_temp;
    logic [63:0] r_s3_v1sq, r_s3_v1p5, r_s3_v1p2;
    logic [31:0] r_s3_mh5, r_s3_mh6, r_s3_mh3;
    logic [63:0] r_s4_p6lo, r_s4_p3lo, r_s4_v1p5, r_s4_v1p2;
    logic [31:0] r_s4_p6hi, r_s4_p3hi, r_s4_lhs, r_s4_inner;
    logic [63:0] r_s5_v2, r_s5_w;
    logic [31:0] r_s5_rm, r_s5_lhs;
    logic [47:0] r_s6_wlo;
    logic [31:0] r_s6_whi, r_s6_hx;
    logic [63:0] r_s6_num;
    logic [31:0] r_s7_den, r_s7_nhi, r_s7_hsq, r_s7_hx;
    logic [43:0] r_s7_nlo;
    logic [63:0] r_s8_num;
    logic [31:0] r_s8_den, r_s8_hm, r_s8_hx;
    t_pre        r_s9_out;

    // intermediate values between registers
    logic [31:0] w_xa, w_d, w_fine, w_t5, w_hx, w_lsum;
    logic [32:0] w_v1;
    logic [63:0] w_v2, w_v1n, w_wp;
    logic [20:0] w_pp;
    logic [31:0] w_hx2, w_hc;
    logic [16:0] w_hq;
    logic [23:0] w_hp;

    always_comb begin
        w_xa   = {15'd0, i_temp_raw[19:3]} - {15'd0, w_t1, 1'b0};
        w_d    = {16'd0, i_temp_raw[19:4]} - {16'd0, w_t1};
        w_fine = r_s1_a + sra32(r_s1_b1, 14);
        w_t5   = (w_fine << 2) + w_fine + TEMP_ROUND_8;
        w_v1   = {r_s2_fine[31], r_s2_fine} - PRESS_FINE_OFS;
        w_hx   = r_s2_fine - HUM_FINE_OFS;
        w_lsum = {2'd0, r_s3_hraw, 14'd0} - {w_h4[11:0], 20'd0} - r_s3_mh5 + HUM_ROUND_14;
        w_v2   = r_s4_p6lo + {r_s4_p6hi, 32'd0} + (r_s4_v1p5 << 17) + (sx16_64(w_p4) << 35);
        w_v1n  = sra64(r_s4_p3lo + {r_s4_p3hi, 32'd0}, 8) + (r_s4_v1p2 << 12);
        w_pp   = PRESS_FULL - {1'b0, r_s5_praw};
        w_wp   = {16'd0, r_s6_wlo} + {r_s6_whi, 32'd0};
        w_hx2  = r_s8_hx - sra32(r_s8_hm, 4);
        // clamp to 0..100 %RH in q10.22
        if (w_hx2[31]) begin
            w_hc = '0;
        end else if (w_hx2 > HUM_MAX_Q10) begin
            w_hc = HUM_MAX_Q10;
        end else begin
            w_hc = w_hx2;
        end
        w_hq = 17'((w_hc + HUM_ROUND_12) >> 12);
        w_hp = (HUM_PCT * {7'd0, w_hq} + HUM_ROUND_10) >> 10;
    end

    // whole front advances together, stalls only when its last stage cannot leave
    assign w_en    = !r_vld[STAGES-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[STAGES-1];
    assign o_data  = r_s9_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // temperature products
            r_s0_ap   <= w_xa * sx16_32(w_t2);
            r_s0_dd   <= w_d * w_d;
            r_s0_praw <= i_press_raw;
            r_s0_hraw <= i_hum_raw;
            r_s1_a    <= sra32(r_s0_ap, 11);
            r_s1_b1   <= sra32(r_s0_dd, 12) * sx16_32(w_t3);
            r_s1_praw <= r_s0_praw;
            r_s1_hraw <= r_s0_hraw;
            // fine temperature and centidegrees
            r_s2_fine <= w_fine;
            r_s2_temp <= sra32(w_t5, 8);
            r_s2_praw <= r_s1_praw;
            r_s2_hraw <= r_s1_hraw;
            // first pressure and humidity products
            r_s3_v1sq <= mul_s33_s33(w_v1, w_v1);
            r_s3_v1p5 <= mul_s33_s16(w_v1, w_p5);
            r_s3_v1p2 <= mul_s33_s16(w_v1, w_p2);
            r_s3_mh5  <= sx16_32(w_h5) * w_hx;
            r_s3_mh6  <= w_hx * sx8_32(w_h6);
            r_s3_mh3  <= {24'd0, w_h3} * w_hx;
            r_s3_hraw <= r_s2_hraw;
            r_s3_praw <= r_s2_praw;
            r_s3_temp <= r_s2_temp;
            // square times p6 and p3 split in halves
            r_s4_p6lo  <= mul_u32_s16(r_s3_v1sq[31:0], w_p6);
            r_s4_p6hi  <= r_s3_v1sq[63:32] * sx16_32(w_p6);
            r_s4_p3lo  <= mul_u32_s16(r_s3_v1sq[31:0], w_p3);
            r_s4_p3hi  <= r_s3_v1sq[63:32] * sx16_32(w_p3);
            r_s4_v1p5  <= r_s3_v1p5;
            r_s4_v1p2  <= r_s3_v1p2;
            r_s4_lhs   <= sra32(w_lsum, 15);
            r_s4_inner <= sra32(r_s3_mh6, 10) * (sra32(r_s3_mh3, 11) + HUM_H3_OFS);
            r_s4_praw  <= r_s3_praw;
            r_s4_temp  <= r_s3_temp;
            // sums of the polynomial terms
            r_s5_v2   <= w_v2;
            r_s5_w    <= PRESS_V1_BIAS + w_v1n;
            r_s5_rm   <= (sra32(r_s4_inner, 10) + HUM_INNER_OFS) * sx16_32(w_h2);
            r_s5_lhs  <= r_s4_lhs;
            r_s5_praw <= r_s4_praw;
            r_s5_temp <= r_s4_temp;
            // divisor product halves, raw numerator
            r_s6_wlo  <= {16'd0, r_s5_w[31:0]} * {32'd0, w_p1};
            r_s6_whi  <= r_s5_w[63:32] * {16'd0, w_p1};
            r_s6_num  <= {12'd0, w_pp, 31'd0} - r_s5_v2;
            r_s6_hx   <= r_s5_lhs * sra32(r_s5_rm + HUM_ROUND_13, 14);
            r_s6_temp <= r_s5_temp;
            // divisor and scaled numerator halves
            r_s7_den  <= {w_wp[63], w_wp[63:33]};
            r_s7_nlo  <= {12'd0, r_s6_num[31:0]} * {32'd0, PRESS_SCALE[11:0]};
            r_s7_nhi  <= r_s6_num[63:32] * PRESS_SCALE;
            r_s7_hsq  <= sra32(r_s6_hx, 15) * sra32(r_s6_hx, 15);
            r_s7_hx   <= r_s6_hx;
            r_s7_temp <= r_s6_temp;
            // dividend and humidity correction
            r_s8_num  <= {20'd0, r_s7_nlo} + {r_s7_nhi, 32'd0};
            r_s8_den  <= r_s7_den;
            r_s8_hm   <= sra32(r_s7_hsq, 7) * {24'd0, w_h1};
            r_s8_hx   <= r_s7_hx;
            r_s8_temp <= r_s7_temp;
            // item ready for the queue
            r_s9_out.dividend  <= r_s8_num;
            r_s9_out.divisor   <= r_s8_den;
            r_s9_out.side.temp <= r_s8_temp;
            r_s9_out.side.hum  <= w_hp[HUM_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/src_fifo.sv
// short queue that decouples the front from the back
module src_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  src_pkg::t_pre i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output src_pkg::t_pre o_data
);
    import src_pkg::*;

    t_pre                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                w_push, w_pop;

    assign o_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(w_push) - (QUEUE_AW+1)'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/src_div.sv
// pipelined signed divider, one quotient bit per stage, truncating toward zero
module src_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [src_pkg::NUM_W-1:0] i_num,
    input  logic [src_pkg::DEN_W-1:0] i_den,
    input  src_pkg::t_side            i_side,
    output logic                      o_valid,
    output src_pkg::t_quot            o_data
);
    import src_pkg::*;

    logic [NUM_W-1:0] r_n    [NUM_W+1];
    logic [DEN_W:0]   r_rem  [NUM_W+1];
    logic [DEN_W-1:0] r_ad   [NUM_W+1];
    logic             r_neg  [NUM_W+1];
    logic             r_zero [NUM_W+1];
    t_side            r_side [NUM_W+1];
    logic [NUM_W:0]   r_vld;
    logic             r_out_vld;
    t_quot            r_out;

    // entry: magnitudes and sign of the quotient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]    <= i_num[NUM_W-1] ? (NUM_W'(0) - i_num) : i_num;
            r_ad[0]   <= i_den[DEN_W-1] ? (DEN_W'(0) - i_den) : i_den;
            r_neg[0]  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_zero[0] <= (i_den == '0);
            r_rem[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    // restoring steps
    for (genvar k = 1; k <= NUM_W; k++) begin : g_step
        logic [DEN_W:0] w_rin, w_diff;
        logic           w_ge;
        assign w_rin  = {r_rem[k-1][DEN_W-1:0], r_n[k-1][NUM_W-1]};
        assign w_ge   = (w_rin >= {1'b0, r_ad[k-1]});
        assign w_diff = w_rin - {1'b0, r_ad[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff : w_rin;
                r_n[k]    <= {r_n[k-1][NUM_W-2:0], w_ge};
                r_ad[k]   <= r_ad[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // sign fix of the quotient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.quo  <= r_neg[NUM_W] ? (NUM_W'(0) - r_n[NUM_W]) : r_n[NUM_W];
            r_out.zero <= r_zero[NUM_W];
            r_out.side <= r_side[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= {r_vld[NUM_W-1:0], i_valid};
            r_out_vld <= r_vld[NUM_W];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

FILE: hw/rtl/src_back.sv
// back part: divides, applies the second-order pressure terms and rounds
module src_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  src_pkg::t_pre               i_data,
    input  logic [63:0]                 i_cal_press_high,
    input  logic [55:0]                 i_cal_mixed,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [src_pkg::TEMP_W-1:0]  o_temp,
    output logic [src_pkg::PRESS_W-1:0] o_press,
    output logic [src_pkg::HUM_W-1:0]   o_hum
);
    import src_pkg::*;

    logic [15:0] w_p7, w_p8, w_p9;
    assign w_p7 = i_cal_press_high[47:32];
    assign w_p8 = i_cal_press_high[63:48];
    assign w_p9 = i_cal_mixed[15:0];

    logic  w_en;
    logic  w_div_vld;
    t_quot w_div;

    logic [3:0]  r_vld;
    logic [63:0] r_b1_p13sq, r_b1_p8lo, r_b1_q, r_b2_p9lo, r_b2_v2, r_b2_q, r_b3_sum;
    logic [31:0] r_b1_p8hi, r_b2_p9hi;
    logic        r_b1_zero, r_b2_zero, r_b3_zero;
    t_side       r_b1_side, r_b2_side, r_b3_side;
    logic [TEMP_W-1:0]  r_temp;
    logic [PRESS_W-1:0] r_press;
    logic [HUM_W-1:0]   r_hum;

    logic [31:0] w_p13;
    logic [63:0] w_p, w_v1;
    logic [31:0] w_round;

    // the whole back advances when its output register can take an item
    assign w_en    = !r_vld[3] || i_ready;
    assign o_ready = w_en;

    src_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_num   (i_data.dividend),
        .i_den   (i_data.divisor),
        .i_side  (i_data.side),
        .o_valid (w_div_vld),
        .o_data  (w_div)
    );

    always_comb begin
        w_p13   = w_div.quo[44:13];
        w_v1    = sra64(r_b2_p9lo + {r_b2_p9hi, 32'd0}, 25);
        w_p     = sra64(r_b3_sum, 8) + (sx16_64(w_p7) << 4);
        w_round = w_p[31:0] + PRESS_ROUND_8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[2:0], w_div_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // square of the scaled quotient, p8 term halves
            r_b1_p13sq <= mul_s32_s32(w_p13, w_p13);
            r_b1_p8lo  <= mul_u32_s16(w_div.quo[31:0], w_p8);
            r_b1_p8hi  <= w_div.quo[63:32] * sx16_32(w_p8);
            r_b1_q     <= w_div.quo;
            r_b1_zero  <= w_div.zero;
            r_b1_side  <= w_div.side;
            // p9 term halves, p8 term done
            r_b2_p9lo  <= mul_u32_s16(r_b1_p13sq[31:0], w_p9);
            r_b2_p9hi  <= r_b1_p13sq[63:32] * sx16_32(w_p9);
            r_b2_v2    <= sra64(r_b1_p8lo + {r_b1_p8hi, 32'd0}, 19);
            r_b2_q     <= r_b1_q;
            r_b2_zero  <= r_b1_zero;
            r_b2_side  <= r_b1_side;
            // sum of the correction terms
            r_b3_sum   <= r_b2_q + w_v1 + r_b2_v2;
            r_b3_zero  <= r_b2_zero;
            r_b3_side  <= r_b2_side;
            // output register, q24.8 rounded to whole pascal
            r_press    <= r_b3_zero ? '0 : w_round[31:8];
            r_temp     <= r_b3_side.temp;
            r_hum      <= r_b3_side.hum;
        end
    end

    assign o_valid = r_vld[3];
    assign o_temp  = r_temp;
    assign o_press = r_press;
    assign o_hum   = r_hum;

endmodule

FILE: tb/tb.sv
// testbench for the sensor compensation block: random calibration sets and readings checked against a local predictor
module tb;
    import src_pkg::*;

    // raw readings, press_raw in the lowest bits
    typedef struct packed {
        logic [HUM_RAW_W-1:0]   hum;
        logic [TEMP_RAW_W-1:0]  temp;
        logic [PRESS_RAW_W-1:0] press;
    } t_raw_set;

    // compensated reading, temperature in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        logic [HUM_W-1:0]   hum;
        logic [PRESS_W-1:0] press;
        logic [TEMP_W-1:0]  temp;
    } t_reading;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd5;
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // calibration shadow, stimulus and expectation stores
    logic [63:0] cal_words [0:4];
    t_raw_set    pending_sets[$];
    t_reading    expected_readings[$];
    int          mismatches;
    int          cycle_count;
    int          tx_gap_max;
    int          rx_mode;
    logic        hold_req;
    logic        hold_taken;
    int          hold_left;
    int          burst_left;
    int          gap_left;

    sensor_reading_compensation i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    // signed divide, truncating toward zero
    function automatic logic [63:0] div_trunc(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] q;
        an = num[63] ? -num : num;
        ad = den[63] ? -den : den;
        q = an / ad;
        return (num[63] != den[63]) ? -q : q;
    endfunction

    // compensation of one set of raw readings with the current calibration
    function automatic t_reading compensate(input t_raw_set r);
        t_reading    res;
        logic [31:0] traw, hraw, t1, t2, t3, a, b, d, fine;
        logic [31:0] h1, h2, h3, h4, h5, h6, x, x15, lhs, inner, rhs, hq, pq;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, p13, num;
        traw = {12'b0, r.temp};
        hraw = {16'b0, r.hum};
        t1 = {16'b0, cal_words[0][15:0]};
        t2 = {{16{cal_words[0][31]}}, cal_words[0][31:16]};
        t3 = {{16{cal_words[0][47]}}, cal_words[0][47:32]};
        p1 = {48'b0, cal_words[1][15:0]};
        p2 = {{48{cal_words[1][31]}}, cal_words[1][31:16]};
        p3 = {{48{cal_words[1][47]}}, cal_words[1][47:32]};
        p4 = {{48{cal_words[1][63]}}, cal_words[1][63:48]};
        p5 = {{48{cal_words[2][15]}}, cal_words[2][15:0]};
        p6 = {{48{cal_words[2][31]}}, cal_words[2][31:16]};
        p7 = {{48{cal_words[2][47]}}, cal_words[2][47:32]};
        p8 = {{48{cal_words[2][63]}}, cal_words[2][63:48]};
        p9 = {{48{cal_words[3][15]}}, cal_words[3][15:0]};
        h1 = {24'b0, cal_words[3][23:16]};
        h2 = {{16{cal_words[3][39]}}, cal_words[3][39:24]};
        h3 = {24'b0, cal_words[3][47:40]};
        h6 = {{24{cal_words[3][55]}}, cal_words[3][55:48]};
        h4 = {{16{cal_words[4][15]}}, cal_words[4][15:0]};
        h5 = {{16{cal_words[4][31]}}, cal_words[4][31:16]};

        // temperature, 32-bit wrap
        a = asr32(((traw >> 3) - (t1 << 1)) * t2, 11);
        d = (traw >> 4) - t1;
        b = asr32(asr32(d * d, 12) * t3, 14);
        fine = a + b;
        res.temp = asr32(fine * 32'd5 + 32'd128, 8);

        // pressure, 64-bit wrap
        p = 64'd0;
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64((64'h0000_8000_0000_0000 + v1) * p1, 33);
        if (v1 != 64'd0) begin
            p = 64'd1048576 - {44'b0, r.press};
            num = ((p << 31) - v2) * 64'd3125;
            p = div_trunc(num, v1);
            p13 = asr64(p, 13);
            p13 = {{32{p13[31]}}, p13[31:0]};
            v1 = asr64(p9 * p13 * p13, 25);
            v2 = asr64(p8 * p, 19);
            p = asr64(p + v1 + v2, 8) + (p7 << 4);
        end
        pq = p[31:0] + 32'd128;
        res.press = pq[31:8];

        // humidity, 32-bit wrap, clamped
        x = fine - 32'd76800;
        lhs = asr32((hraw << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
        inner = asr32(x * h6, 10) * (asr32(h3 * x, 11) + 32'd32768);
        rhs = asr32((asr32(inner, 10) + 32'd2097152) * h2 + 32'd8192, 14);
        x = lhs * rhs;
        x15 = asr32(x, 15);
        x = x - asr32(asr32(x15 * x15, 7) * h1, 4);
        if (x[31]) begin
            x = 32'd0;
        end else if (x > 32'd419430400) begin
            x = 32'd419430400;
        end
        hq = (x + 32'd2048) >> 12;
        hq = (32'd100 * hq + 32'd512) >> 10;
        res.hum = hq[13:0];
        res.pad = 2'b00;
        return res;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    // sender: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                expected_readings.push_back(compensate(t_raw_set'(i_s_axis_tdata)));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_sets.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= pending_sets.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern per mode, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_taken <= 1'b0;
            hold_left <= 0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_left <= 400;
                hold_taken <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
            case (rx_mode)
                0: i_m_axis_tready <= (hold_left == 0);
                1: i_m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 9) < 6);
                default: i_m_axis_tready <= (hold_left == 0) && (cycle_count % 7 < 3);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_reading'(o_m_axis_tdata);
            if (expected_readings.size() == 0) begin
                report("unexpected item", o_m_axis_tdata[63:0], 64'd0);
            end else begin
                want = expected_readings.pop_front();
                if (got.temp !== want.temp)
                    report("temp_centideg", 64'(got.temp), 64'(want.temp));
                if (got.press !== want.press)
                    report("press_pascal", 64'(got.press), 64'(want.press));
                if (got.hum !== want.hum)
                    report("hum_centipct", 64'(got.hum), 64'(want.hum));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_TEMP_WORDS:       cal_words[0] = value & 64'h0000_FFFF_FFFF_FFFF;
            CFG_PRESS_LOW_WORDS:  cal_words[1] = value;
            CFG_PRESS_HIGH_WORDS: cal_words[2] = value;
            CFG_MIXED_WORDS:      cal_words[3] = value & 64'h00FF_FFFF_FFFF_FFFF;
            CFG_HUM_WORDS:        cal_words[4] = value & 64'h0000_0000_FFFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [63:0] w0, input logic [63:0] w1,
                            input logic [63:0] w2, input logic [63:0] w3,
                            input logic [63:0] w4);
        write_reg(CFG_TEMP_WORDS, w0);
        write_reg(CFG_PRESS_LOW_WORDS, w1);
        write_reg(CFG_PRESS_HIGH_WORDS, w2);
        write_reg(CFG_MIXED_WORDS, w3);
        write_reg(CFG_HUM_WORDS, w4);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_sets.size() > 0 || i_s_axis_tvalid || expected_readings.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // half plausible readings, the other half anywhere in range
    function automatic t_raw_set rand_set();
        t_raw_set s;
        if ($urandom_range(0, 1)) begin
            s.press = 20'($urandom_range(200000, 600000));
            s.temp = 20'($urandom_range(380000, 620000));
            s.hum = 16'($urandom_range(15000, 55000));
        end else begin
            s = t_raw_set'(56'({$urandom(), $urandom()}));
            if ($urandom_range(0, 7) == 0) s.press = $urandom_range(0, 1) ? '1 : '0;
            if ($urandom_range(0, 7) == 0) s.temp = $urandom_range(0, 1) ? '1 : '0;
            if ($urandom_range(0, 7) == 0) s.hum = $urandom_range(0, 1) ? '1 : '0;
        end
        return s;
    endfunction

    // stimulus sequence
    initial begin
        logic [63:0] typ_t, typ_pl, typ_ph, typ_m, typ_h;
        typ_t  = 64'({16'(-16'sd1000), 16'd26435, 16'd27504});
        typ_pl = {16'd2855, 16'd3024, 16'(-16'sd10685), 16'd36477};
        typ_ph = {16'(-16'sd14600), 16'd15500, 16'(-16'sd7), 16'd140};
        typ_m  = 64'({8'd30, 8'd0, 16'd370, 8'd75, 16'd6000});
        typ_h  = 64'({16'd50, 16'd313});
        i_rst_n = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        tx_gap_max = 0;
        rx_mode = 0;
        hold_req = 1'b0;
        for (int k = 0; k < 5; k++) cal_words[k] = 64'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: typical part, extremes of every field, zero divisor case
        load_cal(typ_t, typ_pl, typ_ph, typ_m, typ_h);
        pending_sets.push_back('{hum: 16'd30000, temp: 20'd519888, press: 20'd415148});
        pending_sets.push_back('{hum: 16'd0, temp: 20'd0, press: 20'd0});
        pending_sets.push_back('{hum: 16'hFFFF, temp: 20'hFFFFF, press: 20'hFFFFF});
        pending_sets.push_back('{hum: 16'hFFFF, temp: 20'd519888, press: 20'd0});
        pending_sets.push_back('{hum: 16'd0, temp: 20'd519888, press: 20'hFFFFF});
        pending_sets.push_back('{hum: 16'h5555, temp: 20'hAAAAA, press: 20'h55555});
        pending_sets.push_back('{hum: 16'hAAAA, temp: 20'h55555, press: 20'hAAAAA});
        pending_sets.push_back('{hum: 16'd60000, temp: 20'd300000, press: 20'd100000});
        wait_drained();
        write_reg(CFG_NO_REG, rand64());
        load_cal(typ_t, 64'd0, typ_ph, typ_m, typ_h);
        for (int k = 0; k < 6; k++) pending_sets.push_back(rand_set());
        wait_drained();

        // random phases over several calibration settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_cal(typ_t, typ_pl, typ_ph, typ_m, typ_h);
                1: load_cal('0, '0, '0, '0, '0);
                2: load_cal('1, '1, '1, '1, '1);
                3: load_cal(64'({3{16'h7FFF}}), {{3{16'h7FFF}}, 16'hFFFF}, {4{16'h7FFF}},
                            64'({8'h7F, 8'hFF, 16'h7FFF, 8'hFF, 16'h7FFF}),
                            64'({2{16'h7FFF}}));
                4: load_cal(64'({3{16'h8000}}), {{3{16'h8000}}, 16'h0001}, {4{16'h8000}},
                            64'({8'h80, 8'h00, 16'h8000, 8'h00, 16'h8000}),
                            64'({2{16'h8000}}));
                default: load_cal(rand64(), rand64(), rand64(), rand64(), rand64());
            endcase
            tx_gap_max = (ph % 3 == 0) ? 0 : ph;
            rx_mode = ph % 3;
            for (int k = 0; k < 205; k++) pending_sets.push_back(rand_set());
            if (ph == 1) hold_req = 1'b1;
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
